// ----- hdl/joystick_event_correction_filter_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the joystick event correction filter
// Immediate-implication and next-cycle checks, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_EVENT_CORRECTION_FILTER_TOP_ASSERT_SVH
`define JOYSTICK_EVENT_CORRECTION_FILTER_TOP_ASSERT_SVH

// ante holds in a cycle, cons must hold in the same cycle
`define JECF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante holds in a cycle, cons must hold in the next cycle
`define JECF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/jecf_pkg.sv -----
// ---------------------------------------------------------------------------
// jecf_pkg
// Constants and types of the joystick event correction filter.
// ---------------------------------------------------------------------------
package jecf_pkg;

  localparam int NUM_AXIS_CODES = 64;
  localparam int BUTTON_BASE    = 256;
  localparam int NUM_KEY_CODES  = 512;

  localparam int AXW       = $clog2(NUM_AXIS_CODES);
  localparam int BTN_DEPTH = NUM_KEY_CODES - BUTTON_BASE;
  localparam int BTN_AW    = (BTN_DEPTH > 1) ? $clog2(BTN_DEPTH) : 1;

  localparam int OUT_LIMIT  = 32767;
  localparam int GAIN_SHIFT = 14;
  localparam int AUTOREPEAT = 2;

  localparam int IN_DATA_W  = 184;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    MODE_KEY   = 3'd0,
    MODE_AXIS  = 3'd1,
    MODE_CLOAD = 3'd2,
    MODE_AMAP  = 3'd3,
    MODE_BMAP  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LINE = 2'd1
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_BTN   = 2'd1,
    OP_AXIS  = 2'd2,
    OP_CLOAD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RG_ZERO = 2'd0,
    RG_PASS = 2'd1,
    RG_MULT = 2'd2
  } region_e;

  // one row of the correction memory
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] gb;
    logic [31:0] ga;
  } corr_row_t;

  // what every pipeline stage carries
  typedef struct packed {
    op_e            op;
    logic [AXW-1:0] axis;
    logic [7:0]     num;
    logic [31:0]    value;
  } pipe_t;

endpackage

// ----- hdl/joystick_event_correction_filter_top.sv -----
// ---------------------------------------------------------------------------
// joystick_event_correction_filter_top
// Button/axis remap with piecewise-linear dead-zone correction per axis.
// ---------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                                   tuser
//  s_axis    in   code, value, map_index, correction_kind,             mode
//                 low_breakpoint, high_breakpoint, slope_below,
//                 slope_above, zero pad to 184 bits
//  m_axis    out  number, event_value                                  is_axis
//
//  One word is taken per cycle unless the skid is full or tables are clearing;
//  each word passes through the 4-stage read/correct/multiply/write-back
//  pipeline around the remap, correction and last-value memories.
//  After reset a clearing pass zeroes every table; s_axis_tready stays low
//  until it ends.
//  The pipeline freezes only while two results wait at the output.
// ---------------------------------------------------------------------------
`include "joystick_event_correction_filter_top_assert.svh"

module joystick_event_correction_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // code, value, map_index, correction_kind, low_breakpoint,
  // high_breakpoint, slope_below, slope_above
  input  logic [jecf_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // mode
  input  logic [jecf_pkg::IN_USER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // number, event_value
  output logic [jecf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // is_axis
  output logic [0:0]                     m_axis_tuser
);
  import jecf_pkg::*;

  // input fields
  logic [8:0]  in_code;
  logic [31:0] in_value;
  logic [7:0]  in_midx;
  logic [1:0]  in_kind;
  corr_row_t   in_row;
  mode_e       in_mode;

  assign in_code  = s_axis_tdata[8:0];
  assign in_value = s_axis_tdata[40:9];
  assign in_midx  = s_axis_tdata[48:41];
  assign in_kind  = s_axis_tdata[50:49];
  assign in_row   = '{kind: in_kind, lo: s_axis_tdata[82:51], hi: s_axis_tdata[114:83],
                      gb: s_axis_tdata[146:115], ga: s_axis_tdata[178:147]};
  assign in_mode  = mode_e'(s_axis_tuser);

  // memories
  logic [AXW-1:0]   amap_mem [NUM_AXIS_CODES];
  logic [7:0]       bmap_mem [BTN_DEPTH];
  corr_row_t        corr_mem [NUM_AXIS_CODES];
  logic [15:0]      last_mem [NUM_AXIS_CODES];

  // clearing pass after reset
  logic              clr_busy_q;
  logic [BTN_AW-1:0] clr_cnt_q;
  logic [AXW-1:0]    clr_ax;

  assign clr_ax = clr_cnt_q[AXW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + BTN_AW'(1);
      if (clr_cnt_q == BTN_AW'(BTN_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  logic en;
  logic accept;

  // stage valids and payloads
  logic  s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  pipe_t s1_q, s2_q, s3_q, s4_q;
  pipe_t s1_d, s2_d, s3_d;
  corr_row_t s1_row_q, s2_row_q;

  // read data registers
  logic [AXW-1:0] amap_rd_q;
  logic [7:0]     bmap_rd_q;
  corr_row_t      corr_rd_q;
  logic [15:0]    last_rd_q;

  // correction datapath
  region_e            s3_rg_q, s4_rg_q;
  logic signed [32:0] s3_diff_q;
  logic signed [31:0] s3_slope_q;
  logic signed [64:0] s4_prod_q;
  logic               s4_fwd_q;
  logic [15:0]        s4_fwd_val_q;

  // output buffer: head register and skid
  logic        out_vld_q, skid_vld_q;
  logic [40:0] out_q, skid_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en && !clr_busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------- stage 0: decode --------------------------------------
  logic           key_ok, axis_ok, cload_ok, amap_ok, bmap_ok, btn_rng;
  logic [BTN_AW-1:0] btn_addr;
  logic [AXW-1:0]    code_ax;
  pipe_t             s0_p;

  assign btn_rng  = (32'(in_code) >= BUTTON_BASE) && (32'(in_code) < NUM_KEY_CODES);
  assign btn_addr = BTN_AW'(in_code - 9'(BUTTON_BASE));
  assign code_ax  = in_code[AXW-1:0];
  assign key_ok   = (in_mode == MODE_KEY) && btn_rng && (in_value != 32'(AUTOREPEAT));
  assign axis_ok  = (in_mode == MODE_AXIS) && (32'(in_code) < NUM_AXIS_CODES);
  assign cload_ok = (in_mode == MODE_CLOAD) && (32'(in_code) < NUM_AXIS_CODES);
  assign amap_ok  = (in_mode == MODE_AMAP) && (32'(in_code) < NUM_AXIS_CODES)
                    && (32'(in_midx) < NUM_AXIS_CODES);
  assign bmap_ok  = (in_mode == MODE_BMAP) && btn_rng;

  always_comb begin
    s0_p       = '0;
    s0_p.axis  = code_ax;
    s0_p.value = in_value;
    if (key_ok) begin
      s0_p.op = OP_BTN;
    end else if (axis_ok) begin
      s0_p.op = OP_AXIS;
    end else if (cload_ok) begin
      s0_p.op = OP_CLOAD;
    end else begin
      s0_p.op = OP_NONE;
    end
  end

  // remap and correction-row writes happen at accept; remap reads on every enabled cycle
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      amap_mem[clr_ax]    <= '0;
      bmap_mem[clr_cnt_q] <= '0;
      corr_mem[clr_ax]    <= '0;
    end else begin
      if (accept && amap_ok) begin
        amap_mem[code_ax] <= AXW'(in_midx);
      end
      if (accept && bmap_ok) begin
        bmap_mem[btn_addr] <= in_midx;
      end
      if (accept && cload_ok) begin
        corr_mem[code_ax] <= in_row;
      end
    end
    if (en) begin
      amap_rd_q <= amap_mem[code_ax];
      bmap_rd_q <= bmap_mem[btn_addr];
    end
  end

  // ---------------- stage 1: resolve axis, read correction row ----------
  always_comb begin
    s1_d = s1_q;
    if (s1_q.op != OP_CLOAD) begin
      s1_d.axis = amap_rd_q;
    end
    if (s1_q.op == OP_BTN) begin
      s1_d.num = bmap_rd_q;
    end else begin
      s1_d.num = 8'(s1_d.axis);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      corr_rd_q <= corr_mem[s1_d.axis];
    end
  end

  // ---------------- stage 2: region select ------------------------------
  corr_row_t          s2_row;
  logic signed [31:0] s2_v;
  logic               gt_lo, lt_hi;
  region_e            s2_rg;
  logic signed [32:0] s2_diff;
  logic signed [31:0] s2_slope;

  always_comb begin
    s2_d = s2_q;
    if (s2_q.op == OP_CLOAD) begin
      s2_row = s2_row_q;
    end else begin
      s2_row = corr_rd_q;
    end
    s2_v     = $signed(s2_q.value);
    gt_lo    = s2_v > $signed(s2_row.lo);
    lt_hi    = s2_v < $signed(s2_row.hi);
    s2_diff  = '0;
    s2_slope = '0;
    case (s2_row.kind)
      KIND_NONE: s2_rg = RG_PASS;
      KIND_LINE: begin
        if (gt_lo && lt_hi) begin
          s2_rg = RG_ZERO;
        end else if (gt_lo) begin
          s2_rg    = RG_MULT;
          s2_diff  = $signed({s2_v[31], s2_v}) - $signed({s2_row.hi[31], s2_row.hi});
          s2_slope = $signed(s2_row.ga);
        end else begin
          s2_rg    = RG_MULT;
          s2_diff  = $signed({s2_v[31], s2_v}) - $signed({s2_row.lo[31], s2_row.lo});
          s2_slope = $signed(s2_row.gb);
        end
      end
      default: s2_rg = RG_ZERO;
    endcase
  end

  // ---------------- stage 3: multiply, read last value ------------------
  always_comb begin
    s3_d = s3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_rd_q <= last_mem[s3_d.axis];
    end
  end

  // ---------------- stage 4: shift, saturate, compare, write back -------
  function automatic logic [15:0] sat16(input logic signed [64:0] x);
    logic signed [64:0] lim_p;
    logic signed [64:0] lim_n;
    lim_p = $signed(65'(OUT_LIMIT));
    lim_n = $signed(65'(-OUT_LIMIT));
    if (x > lim_p) begin
      sat16 = 16'(OUT_LIMIT);
    end else if (x < lim_n) begin
      sat16 = 16'(-OUT_LIMIT);
    end else begin
      sat16 = x[15:0];
    end
  endfunction

  logic [15:0] s4_r;
  logic [15:0] s4_last;
  logic        s4_we, s4_emit;
  logic [40:0] s4_res;

  always_comb begin
    case (s4_rg_q)
      RG_PASS: s4_r = sat16(65'($signed(s4_q.value)));
      RG_MULT: s4_r = sat16(s4_prod_q >>> GAIN_SHIFT);
      default: s4_r = '0;
    endcase
    if (s4_fwd_q) begin
      s4_last = s4_fwd_val_q;
    end else begin
      s4_last = last_rd_q;
    end
    s4_we   = 1'b0;
    s4_emit = 1'b0;
    s4_res  = {1'b1, {{16{s4_r[15]}}, s4_r}, s4_q.num};
    if (s4_vld_q) begin
      case (s4_q.op)
        OP_BTN: begin
          s4_emit = 1'b1;
          s4_res  = {1'b0, s4_q.value, s4_q.num};
        end
        OP_AXIS: begin
          s4_emit = (s4_r != s4_last);
          s4_we   = s4_emit;
        end
        OP_CLOAD: s4_we = 1'b1;
        default: s4_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      last_mem[clr_ax] <= '0;
    end else if (en && s4_we) begin
      last_mem[s4_q.axis] <= s4_r;
    end
  end

  // ---------------- pipeline registers ----------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      s4_vld_q   <= 1'b0;
      s4_fwd_q   <= 1'b0;
    end else if (en) begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      // bypass a write-back that lands on the entry being read
      s4_fwd_q <= s4_we && (s4_q.axis == s3_d.axis);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q         <= accept ? s0_p : '0;
      s1_row_q     <= in_row;
      s2_q         <= s1_d;
      s2_row_q     <= s1_row_q;
      s3_q         <= s2_d;
      s3_rg_q      <= s2_rg;
      s3_diff_q    <= s2_diff;
      s3_slope_q   <= s2_slope;
      s4_q         <= s3_d;
      s4_rg_q      <= s3_rg_q;
      s4_prod_q    <= s3_slope_q * s3_diff_q;
      s4_fwd_val_q <= s4_r;
    end
  end

  // ---------------- output buffer ---------------------------------------
  logic push, pop;

  assign push = en && s4_emit;
  assign pop  = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push;
      end
    end else if (push) begin
      if (out_vld_q) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= s4_res;
      end
    end else if (push) begin
      if (out_vld_q) begin
        skid_q <= s4_res;
      end else begin
        out_q <= s4_res;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q[39:0];
  assign m_axis_tuser  = out_q[40];

  // ---------------- assertions ------------------------------------------
  `JECF_ASSERT_NOW(a_skid_behind_head, skid_vld_q, out_vld_q,
    "skid word held without a head word")
  `JECF_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(s4_vld_q) && $stable(s3_vld_q),
    "pipeline moved while stalled")
  `JECF_ASSERT_NOW(a_axis_in_range, m_axis_tvalid && m_axis_tuser[0],
    ($signed(m_axis_tdata[39:8]) <= 32767) && ($signed(m_axis_tdata[39:8]) >= -32767),
    "axis word outside the saturation limits")
  `JECF_ASSERT_NOW(a_hold_during_clear, clr_busy_q, !s_axis_tready,
    "input word taken while tables are clearing")

endmodule

// ----- bench/jecf_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// jecf_checker
// Watches both stream channels of the event correction filter, keeps its own
// copy of the remap and correction tables, predicts each button and axis
// report and compares every output word field by field, in order.
// ---------------------------------------------------------------------------
module jecf_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // code, value, map_index, correction_kind, low_breakpoint,
  // high_breakpoint, slope_below, slope_above
  input  logic [jecf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic [jecf_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // number, event_value
  input  logic [jecf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // is_axis
  input  logic [0:0]                      m_axis_tuser,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              button_seen_o,
  output int                              axis_seen_o
);
  import jecf_pkg::*;

  typedef struct packed {
    logic [4:0]         pad;
    logic signed [31:0] slope_above;
    logic signed [31:0] slope_below;
    logic signed [31:0] high_bp;
    logic signed [31:0] low_bp;
    logic [1:0]         kind;
    logic [7:0]         map_index;
    logic signed [31:0] value;
    logic [8:0]         code;
  } in_word_t;

  typedef struct packed {
    logic        is_axis;
    logic [7:0]  number;
    logic [31:0] value;
  } report_t;

  logic [AXW-1:0] axis_map   [NUM_AXIS_CODES];
  logic [7:0]     button_map [BTN_DEPTH];
  logic [1:0]     kind_tab   [NUM_AXIS_CODES];
  int             dead_low   [NUM_AXIS_CODES];
  int             dead_high  [NUM_AXIS_CODES];
  int             gain_below [NUM_AXIS_CODES];
  int             gain_above [NUM_AXIS_CODES];
  int             last_value [NUM_AXIS_CODES];

  report_t due_reports[$];
  int      fails;
  int      buttons_seen;
  int      axes_seen;

  // Broken-line dead zone correction for one axis, saturated to the output range.
  function automatic int corrected_value(input int v, input int ax);
    longint r;
    case (kind_tab[ax])
      KIND_NONE: r = v;
      KIND_LINE: begin
        if (v > dead_low[ax]) begin
          if (v < dead_high[ax])
            r = 0;
          else
            r = (longint'(gain_above[ax]) * (longint'(v) - longint'(dead_high[ax])))
                >>> GAIN_SHIFT;
        end else begin
          r = (longint'(gain_below[ax]) * (longint'(v) - longint'(dead_low[ax])))
              >>> GAIN_SHIFT;
        end
      end
      default: return 0;
    endcase
    if (r < -OUT_LIMIT) r = -OUT_LIMIT;
    if (r > OUT_LIMIT) r = OUT_LIMIT;
    return int'(r);
  endfunction

  task automatic route_word(input logic [2:0] mode, input in_word_t w);
    report_t rep;
    int      n;
    int      c;
    case (mode)
      MODE_KEY: begin
        // drop keys below the button range and autorepeat
        if (w.code >= BUTTON_BASE && w.code < NUM_KEY_CODES && w.value != AUTOREPEAT) begin
          rep.is_axis = 1'b0;
          rep.number  = button_map[w.code - BUTTON_BASE];
          rep.value   = w.value;
          due_reports.push_back(rep);
        end
      end
      MODE_AXIS: begin
        if (w.code < NUM_AXIS_CODES) begin
          n = axis_map[w.code];
          c = corrected_value(w.value, n);
          // report only a change of the corrected value
          if (c != last_value[n]) begin
            last_value[n] = c;
            rep.is_axis   = 1'b1;
            rep.number    = 8'(n);
            rep.value     = c;
            due_reports.push_back(rep);
          end
        end
      end
      MODE_CLOAD: begin
        if (w.code < NUM_AXIS_CODES) begin
          kind_tab[w.code]   = w.kind;
          dead_low[w.code]   = w.low_bp;
          dead_high[w.code]  = w.high_bp;
          gain_below[w.code] = w.slope_below;
          gain_above[w.code] = w.slope_above;
          last_value[w.code] = corrected_value(w.value, w.code);
        end
      end
      MODE_AMAP: begin
        if (w.code < NUM_AXIS_CODES && w.map_index < NUM_AXIS_CODES)
          axis_map[w.code] = w.map_index[AXW-1:0];
      end
      MODE_BMAP: begin
        if (w.code >= BUTTON_BASE && w.code < NUM_KEY_CODES)
          button_map[w.code - BUTTON_BASE] = w.map_index;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    report_t got;
    report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXIS_CODES; i++) begin
        axis_map[i]   = '0;
        kind_tab[i]   = KIND_NONE;
        dead_low[i]   = 0;
        dead_high[i]  = 0;
        gain_below[i] = 0;
        gain_above[i] = 0;
        last_value[i] = 0;
      end
      for (int i = 0; i < BTN_DEPTH; i++)
        button_map[i] = '0;
      due_reports.delete();
      fails        = 0;
      buttons_seen = 0;
      axes_seen    = 0;
    end else begin
      // compare the outgoing word first: it always belongs to an older input word
      if (m_axis_tvalid && m_axis_tready) begin
        got.is_axis = m_axis_tuser[0];
        got.number  = m_axis_tdata[7:0];
        got.value   = m_axis_tdata[39:8];
        if (got.is_axis) axes_seen++;
        else buttons_seen++;
        if (due_reports.size() == 0) begin
          $display("%0t: unexpected result word, is_axis %0d number %0d value %0d",
                   $time, got.is_axis, got.number, $signed(got.value));
          fails++;
        end else begin
          want = due_reports.pop_front();
          if (got.is_axis !== want.is_axis) begin
            $display("%0t: is_axis mismatch, expected %0d, got %0d",
                     $time, want.is_axis, got.is_axis);
            fails++;
          end
          if (got.number !== want.number) begin
            $display("%0t: number mismatch, expected %0d, got %0d",
                     $time, want.number, got.number);
            fails++;
          end
          if (got.value !== want.value) begin
            $display("%0t: event_value mismatch, expected %0d, got %0d",
                     $time, $signed(want.value), $signed(got.value));
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        route_word(s_axis_tuser, in_word_t'(s_axis_tdata));
    end
    fail_count_o  <= fails;
    pending_o     <= due_reports.size();
    button_seen_o <= buttons_seen;
    axis_seen_o   <= axes_seen;
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives the event correction filter with directed corner words, then random
// table loads and key/axis traffic with random gaps and output stalls; the
// checker beside the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module testbench;
  import jecf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 1120;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CALM_FIRST     = 400;
  localparam int CALM_LAST      = 650;

  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [1:0] KIND_ZERO        = 2'd2;
  localparam logic [1:0] KIND_ZERO_TOP    = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  logic calm = 1'b0;
  int   quiet_cycles = 0;
  int   words_sent = 0;
  int   fails;
  int   pending;
  int   buttons_seen;
  int   axes_seen;

  always #5ns clk_i = ~clk_i;

  joystick_event_correction_filter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  jecf_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fails),
    .pending_o    (pending),
    .button_seen_o(buttons_seen),
    .axis_seen_o  (axes_seen)
  );

  // output stalls, none during the calm stretch
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_reading();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 80000) - 40000;
    endcase
  endfunction

  task automatic send_word(input logic [2:0]  mode,
                           input logic [8:0]  code,
                           input logic [31:0] value,
                           input logic [7:0]  midx = '0,
                           input logic [1:0]  kind = KIND_NONE,
                           input logic [31:0] lo = '0,
                           input logic [31:0] hi = '0,
                           input logic [31:0] gb = '0,
                           input logic [31:0] ga = '0);
    while (!calm && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {5'd0, ga, gb, hi, lo, kind, midx, value, code};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  initial begin : stimulus
    logic [2:0]  mode;
    logic [8:0]  code;
    logic [31:0] value;
    logic [31:0] last_reading;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] gb;
    logic [31:0] ga;
    logic [7:0]  midx;
    logic [1:0]  kind;
    int          pick;

    last_reading = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keys: lowest button, below the range, autorepeat, extreme values
    send_word(MODE_KEY, 9'd256, 32'd1);
    send_word(MODE_KEY, 9'd255, 32'd1);
    send_word(MODE_KEY, 9'd300, AUTOREPEAT);
    send_word(MODE_BMAP, 9'd511, '0, 8'hff);
    send_word(MODE_BMAP, 9'd255, '0, 8'h11);
    send_word(MODE_KEY, 9'd511, 32'h7fff_ffff);
    send_word(MODE_KEY, 9'd511, 32'h8000_0000);
    // axes without correction: unchanged value, both saturation limits, bad codes
    send_word(MODE_AXIS, 9'd0, 32'd0);
    send_word(MODE_AXIS, 9'd0, 32'd100000);
    send_word(MODE_AXIS, 9'd0, 32'h8000_0000);
    send_word(MODE_AXIS, 9'd64, 32'd5);
    // axis map, with out-of-range code and out-of-range target ignored
    send_word(MODE_AMAP, 9'd5, '0, 8'd63);
    send_word(MODE_AMAP, 9'd64, '0, 8'd1);
    send_word(MODE_AMAP, 9'd5, '0, 8'd64);
    // broken line: inside dead zone, above, below
    send_word(MODE_CLOAD, 9'd63, '0, '0, KIND_LINE, -32'sd100, 32'sd100, 32'sd32768, 32'sd16384);
    send_word(MODE_AXIS, 9'd5, 32'd50);
    send_word(MODE_AXIS, 9'd5, 32'd1000);
    send_word(MODE_AXIS, 9'd5, -32'sd101);
    // negative product rounds toward minus infinity on the reseed
    send_word(MODE_CLOAD, 9'd63, -32'sd101, '0, KIND_LINE, -32'sd100, 32'sd100, 32'sd1, 32'sd1);
    send_word(MODE_AXIS, 9'd5, 32'd200);
    // widest products, both signs
    send_word(MODE_CLOAD, 9'd63, '0, '0, KIND_LINE, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, '0);
    send_word(MODE_AXIS, 9'd5, 32'h7fff_ffff);
    send_word(MODE_AXIS, 9'd5, 32'h8000_0000);
    send_word(MODE_CLOAD, 9'd63, 32'h8000_0000, '0, KIND_LINE, 32'h8000_0000, 32'h8000_0000,
              '0, 32'h8000_0000);
    send_word(MODE_AXIS, 9'd5, 32'h7fff_ffff);
    // kinds that force zero, load for a missing axis, spare modes
    send_word(MODE_CLOAD, 9'd63, 32'd5, '0, KIND_ZERO);
    send_word(MODE_CLOAD, 9'd63, 32'd5, '0, KIND_ZERO_TOP);
    send_word(MODE_AXIS, 9'd5, 32'd12345);
    send_word(MODE_CLOAD, 9'd64, 32'd5, '0, KIND_LINE);
    send_word(MODE_SPARE_FIRST, 9'd0, 32'd7);
    send_word(MODE_SPARE_LAST, 9'd511, 32'hffff_ffff);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm <= (i >= CALM_FIRST && i < CALM_LAST);
      // unused fields keep their random content
      code  = 9'($urandom());
      value = $urandom();
      midx  = 8'($urandom());
      kind  = 2'($urandom());
      lo    = $urandom();
      hi    = $urandom();
      gb    = $urandom();
      ga    = $urandom();
      pick  = $urandom_range(0, 99);
      if (pick < 45) begin
        mode = MODE_AXIS;
        case ($urandom_range(0, 9))
          0:       ;
          1, 2:    code = 9'($urandom_range(0, NUM_AXIS_CODES - 1));
          default: code = 9'($urandom_range(0, 7));
        endcase
        value = ($urandom_range(0, 4) == 0) ? last_reading : rand_reading();
        last_reading = value;
      end else if (pick < 62) begin
        mode = MODE_KEY;
        if ($urandom_range(0, 4) != 0)
          code = 9'($urandom_range(BUTTON_BASE, NUM_KEY_CODES - 1));
        value = ($urandom_range(0, 3) == 0) ? AUTOREPEAT : rand_reading();
      end else if (pick < 74) begin
        mode = MODE_CLOAD;
        if ($urandom_range(0, 9) != 0) code = 9'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
          0, 1:    kind = KIND_NONE;
          2, 3:    ;
          default: kind = KIND_LINE;
        endcase
        if ($urandom_range(0, 4) != 0) begin
          lo = -$urandom_range(0, 20000);
          hi = $urandom_range(0, 20000);
        end
        if ($urandom_range(0, 3) != 0) gb = $urandom_range(0, 65536) - 32768;
        if ($urandom_range(0, 3) != 0) ga = $urandom_range(0, 65536) - 32768;
        value = rand_reading();
      end else if (pick < 84) begin
        mode = MODE_AMAP;
        if ($urandom_range(0, 6) != 0) code = 9'($urandom_range(0, 7));
        if ($urandom_range(0, 6) != 0) midx = 8'($urandom_range(0, 7));
      end else if (pick < 94) begin
        mode = MODE_BMAP;
        if ($urandom_range(0, 4) != 0)
          code = 9'($urandom_range(BUTTON_BASE, NUM_KEY_CODES - 1));
      end else begin
        mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end
      send_word(mode, code, value, midx, kind, lo, hi, gb, ga);
    end
    s_axis_tvalid <= 1'b0;
    calm <= 1'b0;

    // let the checker's count catch up with the last accepted word
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words: directed corners, then random key, axis, correction and map loads.",
             words_sent);
    $display("Checked %0d button and %0d axis results under random gaps and stalls.",
             buttons_seen, axes_seen);
    if (fails == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/jecf_pkg.sv
hdl/joystick_event_correction_filter_top.sv
bench/jecf_checker.sv
bench/testbench.sv
